// ===== sv/gcb_pkg.sv =====
// Shared constants, types and packing widths of the greedy change breakdown unit.
`timescale 1ns / 1ps
`default_nettype none
package gcb_pkg;

    // Width of payment, price and the internal change amount.
    localparam int AMOUNT_WIDTH = 20;
    localparam logic [AMOUNT_WIDTH-1:0] PRICE_RESET = AMOUNT_WIDTH'(3257);

    // Result field widths.
    localparam int TOTAL_W    = 20;
    localparam int THOUSAND_W = 11;
    localparam int REM_W      = 10;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((AMOUNT_WIDTH + 7) / 8) * 8;
    localparam int M_FIELD_W = TOTAL_W + THOUSAND_W + 12;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Division by 1000 through a truncated reciprocal; the estimate is at most one low.
    localparam int RECIP_SHIFT = AMOUNT_WIDTH + 10;
    localparam int RECIP_W     = AMOUNT_WIDTH + 1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd1000;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = AMOUNT_WIDTH + RECIP_W;
    localparam int QUOT_W = (AMOUNT_WIDTH > 10) ? AMOUNT_WIDTH - 9 : 1;
    localparam int EXT_W  = AMOUNT_WIDTH + 11;
    localparam logic [EXT_W-1:0] DENOM_THOUSAND_EXT = EXT_W'(1000);

    // Denominations below 1000, sized to the remainder.
    localparam logic [REM_W-1:0] DENOM_500 = REM_W'(500);
    localparam logic [REM_W-1:0] DENOM_400 = REM_W'(400);
    localparam logic [REM_W-1:0] DENOM_200 = REM_W'(200);
    localparam logic [REM_W-1:0] DENOM_100 = REM_W'(100);
    localparam logic [6:0] DENOM_50 = 7'd50;
    localparam logic [6:0] DENOM_40 = 7'd40;
    localparam logic [6:0] DENOM_20 = 7'd20;
    localparam logic [6:0] DENOM_10 = 7'd10;
    localparam logic [3:0] DENOM_5  = 4'd5;
    localparam logic [3:0] DENOM_4  = 4'd4;
    localparam logic [3:0] DENOM_2  = 4'd2;

    // Change status codes.
    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_INSUFFICIENT = 1'b1;

    // After the price subtraction.
    typedef struct packed {
        logic                    valid;
        logic                    status;
        logic [AMOUNT_WIDTH-1:0] rest;
    } gcb_rest_t;

    // After the division by 1000.
    typedef struct packed {
        logic                    valid;
        logic                    status;
        logic [AMOUNT_WIDTH-1:0] rest;
        logic [THOUSAND_W-1:0]   thousand;
        logic [REM_W-1:0]        rem;
    } gcb_high_t;

    // Finished result.
    typedef struct packed {
        logic                  valid;
        logic                  status;
        logic [TOTAL_W-1:0]    total;
        logic [THOUSAND_W-1:0] thousand;
        logic                  n500;
        logic [1:0]            n200;
        logic                  n100;
        logic                  n50;
        logic [1:0]            n20;
        logic                  n10;
        logic                  n5;
        logic [1:0]            n2;
        logic                  n1;
    } gcb_result_t;

endpackage
`default_nettype wire

// ===== sv/gcb_thousand_div.sv =====
// Two-stage division of the change amount by 1000 (reciprocal multiply, then correction).
`timescale 1ns / 1ps
`default_nettype none
module gcb_thousand_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire gcb_pkg::gcb_rest_t in_stage,
    output gcb_pkg::gcb_high_t      out_stage
);

    // Stage 1: product with the reciprocal
    logic                             p_valid_reg;
    logic                             p_status_reg;
    logic [gcb_pkg::AMOUNT_WIDTH-1:0] p_rest_reg;
    logic [gcb_pkg::PROD_W-1:0]       p_prod_reg;
    logic [gcb_pkg::PROD_W-1:0]       p_prod_next;

    // Stage 2: quotient and remainder
    gcb_pkg::gcb_high_t               q_reg;
    gcb_pkg::gcb_high_t               q_next;

    logic [gcb_pkg::QUOT_W-1:0]       q_est;
    logic [gcb_pkg::QUOT_W-1:0]       q_fix;
    logic [gcb_pkg::EXT_W-1:0]        rem_est;
    logic [gcb_pkg::EXT_W-1:0]        rem_fix;

    assign p_prod_next = gcb_pkg::PROD_W'(in_stage.rest) * gcb_pkg::PROD_W'(gcb_pkg::RECIP_MULT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_stage.valid;
        end
        if (en) begin
            p_status_reg <= in_stage.status;
            p_rest_reg   <= in_stage.rest;
            p_prod_reg   <= p_prod_next;
        end
    end

    always_comb begin
        q_est   = gcb_pkg::QUOT_W'(p_prod_reg >> gcb_pkg::RECIP_SHIFT);
        rem_est = gcb_pkg::EXT_W'(p_rest_reg)
                - gcb_pkg::EXT_W'(q_est) * gcb_pkg::DENOM_THOUSAND_EXT;
        // estimate may be one short
        if (rem_est >= gcb_pkg::DENOM_THOUSAND_EXT) begin
            q_fix   = q_est + gcb_pkg::QUOT_W'(1);
            rem_fix = rem_est - gcb_pkg::DENOM_THOUSAND_EXT;
        end else begin
            q_fix   = q_est;
            rem_fix = rem_est;
        end
        q_next.valid    = p_valid_reg;
        q_next.status   = p_status_reg;
        q_next.rest     = p_rest_reg;
        q_next.thousand = gcb_pkg::THOUSAND_W'(q_fix);
        q_next.rem      = gcb_pkg::REM_W'(rem_fix);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg.valid <= q_next.valid;
        end
        if (en) begin
            q_reg.status   <= q_next.status;
            q_reg.rest     <= q_next.rest;
            q_reg.thousand <= q_next.thousand;
            q_reg.rem      <= q_next.rem;
        end
    end

    assign out_stage = q_reg;

    a_rem_below_thousand: assert property (@(posedge aclk) disable iff (!aresetn)
        q_reg.valid |-> (q_reg.rem < gcb_pkg::DENOM_100 * gcb_pkg::REM_W'(10)))
        else $error("remainder after thousands not below 1000");

    a_one_correction: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> (rem_fix < gcb_pkg::DENOM_THOUSAND_EXT))
        else $error("reciprocal estimate off by more than one");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && !en) |=> ($stable(p_prod_reg) && $stable(p_rest_reg)))
        else $error("product stage changed while stalled");

endmodule
`default_nettype wire

// ===== sv/gcb_coin_stages.sv =====
// Three stages of greedy counting over 500 down to 1; the last is the output register.
`timescale 1ns / 1ps
`default_nettype none
module gcb_coin_stages (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire gcb_pkg::gcb_high_t in_stage,
    output gcb_pkg::gcb_result_t    out_stage
);

    // Stage A: 500, 200, 100
    logic                           a_valid_reg;
    logic                           a_status_reg;
    logic [gcb_pkg::TOTAL_W-1:0]    a_total_reg;
    logic [gcb_pkg::THOUSAND_W-1:0] a_thousand_reg;
    logic                           a_n500_reg;
    logic [1:0]                     a_n200_reg;
    logic                           a_n100_reg;
    logic [6:0]                     a_rem_reg;

    // Stage B: 50, 20, 10
    logic                           b_valid_reg;
    logic                           b_status_reg;
    logic [gcb_pkg::TOTAL_W-1:0]    b_total_reg;
    logic [gcb_pkg::THOUSAND_W-1:0] b_thousand_reg;
    logic                           b_n500_reg;
    logic [1:0]                     b_n200_reg;
    logic                           b_n100_reg;
    logic                           b_n50_reg;
    logic [1:0]                     b_n20_reg;
    logic                           b_n10_reg;
    logic [3:0]                     b_rem_reg;

    // Stage C: 5, 2, 1
    gcb_pkg::gcb_result_t           c_reg;
    gcb_pkg::gcb_result_t           c_next;

    logic                           a_n500_next;
    logic [1:0]                     a_n200_next;
    logic                           a_n100_next;
    logic [6:0]                     a_rem_next;
    logic [gcb_pkg::REM_W-1:0]      r1;
    logic [gcb_pkg::REM_W-1:0]      r2;
    logic [gcb_pkg::REM_W-1:0]      r3;

    logic                           b_n50_next;
    logic [1:0]                     b_n20_next;
    logic                           b_n10_next;
    logic [3:0]                     b_rem_next;
    logic [6:0]                     s1;
    logic [6:0]                     s2;
    logic [6:0]                     s3;

    logic [3:0]                     t1;
    logic [3:0]                     t2;

    always_comb begin
        a_n500_next = (in_stage.rem >= gcb_pkg::DENOM_500);
        r1 = a_n500_next ? in_stage.rem - gcb_pkg::DENOM_500 : in_stage.rem;
        if (r1 >= gcb_pkg::DENOM_400) begin
            a_n200_next = 2'd2;
            r2 = r1 - gcb_pkg::DENOM_400;
        end else if (r1 >= gcb_pkg::DENOM_200) begin
            a_n200_next = 2'd1;
            r2 = r1 - gcb_pkg::DENOM_200;
        end else begin
            a_n200_next = 2'd0;
            r2 = r1;
        end
        a_n100_next = (r2 >= gcb_pkg::DENOM_100);
        r3 = a_n100_next ? r2 - gcb_pkg::DENOM_100 : r2;
        a_rem_next = r3[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_stage.valid;
        end
        if (en) begin
            a_status_reg   <= in_stage.status;
            a_total_reg    <= gcb_pkg::TOTAL_W'(in_stage.rest);
            a_thousand_reg <= in_stage.thousand;
            a_n500_reg     <= a_n500_next;
            a_n200_reg     <= a_n200_next;
            a_n100_reg     <= a_n100_next;
            a_rem_reg      <= a_rem_next;
        end
    end

    always_comb begin
        b_n50_next = (a_rem_reg >= gcb_pkg::DENOM_50);
        s1 = b_n50_next ? a_rem_reg - gcb_pkg::DENOM_50 : a_rem_reg;
        if (s1 >= gcb_pkg::DENOM_40) begin
            b_n20_next = 2'd2;
            s2 = s1 - gcb_pkg::DENOM_40;
        end else if (s1 >= gcb_pkg::DENOM_20) begin
            b_n20_next = 2'd1;
            s2 = s1 - gcb_pkg::DENOM_20;
        end else begin
            b_n20_next = 2'd0;
            s2 = s1;
        end
        b_n10_next = (s2 >= gcb_pkg::DENOM_10);
        s3 = b_n10_next ? s2 - gcb_pkg::DENOM_10 : s2;
        b_rem_next = s3[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en) begin
            b_status_reg   <= a_status_reg;
            b_total_reg    <= a_total_reg;
            b_thousand_reg <= a_thousand_reg;
            b_n500_reg     <= a_n500_reg;
            b_n200_reg     <= a_n200_reg;
            b_n100_reg     <= a_n100_reg;
            b_n50_reg      <= b_n50_next;
            b_n20_reg      <= b_n20_next;
            b_n10_reg      <= b_n10_next;
            b_rem_reg      <= b_rem_next;
        end
    end

    always_comb begin
        c_next.valid    = b_valid_reg;
        c_next.status   = b_status_reg;
        c_next.total    = b_total_reg;
        c_next.thousand = b_thousand_reg;
        c_next.n500     = b_n500_reg;
        c_next.n200     = b_n200_reg;
        c_next.n100     = b_n100_reg;
        c_next.n50      = b_n50_reg;
        c_next.n20      = b_n20_reg;
        c_next.n10      = b_n10_reg;
        c_next.n5       = (b_rem_reg >= gcb_pkg::DENOM_5);
        t1 = c_next.n5 ? b_rem_reg - gcb_pkg::DENOM_5 : b_rem_reg;
        if (t1 >= gcb_pkg::DENOM_4) begin
            c_next.n2 = 2'd2;
            t2 = t1 - gcb_pkg::DENOM_4;
        end else if (t1 >= gcb_pkg::DENOM_2) begin
            c_next.n2 = 2'd1;
            t2 = t1 - gcb_pkg::DENOM_2;
        end else begin
            c_next.n2 = 2'd0;
            t2 = t1;
        end
        c_next.n1 = t2[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.valid <= 1'b0;
        end else if (en) begin
            c_reg.valid <= c_next.valid;
        end
        if (en) begin
            c_reg.status   <= c_next.status;
            c_reg.total    <= c_next.total;
            c_reg.thousand <= c_next.thousand;
            c_reg.n500     <= c_next.n500;
            c_reg.n200     <= c_next.n200;
            c_reg.n100     <= c_next.n100;
            c_reg.n50      <= c_next.n50;
            c_reg.n20      <= c_next.n20;
            c_reg.n10      <= c_next.n10;
            c_reg.n5       <= c_next.n5;
            c_reg.n2       <= c_next.n2;
            c_reg.n1       <= c_next.n1;
        end
    end

    assign out_stage = c_reg;

    a_rem_below_hundred: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg |-> (a_rem_reg < 7'd100))
        else $error("remainder after hundreds not below 100");

    a_rem_below_ten: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_rem_reg < gcb_pkg::DENOM_10[3:0]))
        else $error("remainder after tens not below 10");

    a_short_all_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_reg.valid && c_reg.status == gcb_pkg::STATUS_INSUFFICIENT) |->
        (c_reg.total == '0 && c_reg.thousand == '0 && !c_reg.n500 && c_reg.n200 == 2'd0
         && !c_reg.n100 && !c_reg.n50 && c_reg.n20 == 2'd0 && !c_reg.n10 && !c_reg.n5
         && c_reg.n2 == 2'd0 && !c_reg.n1))
        else $error("insufficient payment with nonzero change");

endmodule
`default_nettype wire

// ===== sv/greedy_change_breakdown_unit.sv =====
// Top level of the greedy change breakdown unit: price register, subtract stage, stream ports.
//
// Each payment on the slave stream is checked against the article price (written through
// cfg_wr_en / cfg_wr_data, reset value 3257) and the change is split greedily into counts
// of 1000, 500, 200, 100, 50, 20, 10, 5, 2 and 1. A payment below the price returns
// tuser = 1 with all counts and the total at zero. The datapath is a six-register pipeline
// (subtract, reciprocal multiply for the thousands, correction, then three stages of small
// denominations, the last being the output register), so a transfer may enter every cycle
// and its result passes through all six registers; the only throttle is m_tready, which
// stalls all stages together. Change the price only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module greedy_change_breakdown_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gcb_pkg::AMOUNT_WIDTH-1:0] cfg_wr_data,  // article_price
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [gcb_pkg::S_TDATA_W-1:0]   s_tdata,       // payment_amount
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // change_total, count_thousand, count_five_hundred, count_two_hundred, count_hundred,
    // count_fifty, count_twenty, count_ten, count_five, count_two, count_one
    output logic [gcb_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tuser        // change_status
);

    logic [gcb_pkg::AMOUNT_WIDTH-1:0] price_reg;
    gcb_pkg::gcb_rest_t               sub_reg;
    gcb_pkg::gcb_rest_t               sub_next;
    gcb_pkg::gcb_high_t               high_stage;
    gcb_pkg::gcb_result_t             result;
    logic                             en;
    logic [gcb_pkg::AMOUNT_WIDTH-1:0] pay;

    // whole pipeline advances unless the output holds an untaken result
    assign en       = !result.valid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_reg <= gcb_pkg::PRICE_RESET;
        end else if (cfg_wr_en) begin
            price_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        pay            = s_tdata[gcb_pkg::AMOUNT_WIDTH-1:0];
        sub_next.valid = s_tvalid;
        if (pay < price_reg) begin
            sub_next.status = gcb_pkg::STATUS_INSUFFICIENT;
            sub_next.rest   = '0;
        end else begin
            sub_next.status = gcb_pkg::STATUS_OK;
            sub_next.rest   = pay - price_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg.valid <= 1'b0;
        end else if (en) begin
            sub_reg.valid <= sub_next.valid;
        end
        if (en) begin
            sub_reg.status <= sub_next.status;
            sub_reg.rest   <= sub_next.rest;
        end
    end

    gcb_thousand_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_stage  (sub_reg),
        .out_stage (high_stage)
    );

    gcb_coin_stages u_coins (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_stage  (high_stage),
        .out_stage (result)
    );

    assign m_tvalid = result.valid;
    assign m_tuser  = result.status;
    assign m_tdata  = gcb_pkg::M_TDATA_W'({result.n1, result.n2, result.n5, result.n10,
                                           result.n20, result.n50, result.n100, result.n200,
                                           result.n500, result.thousand, result.total});

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_short_means_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (sub_reg.valid && sub_reg.status == gcb_pkg::STATUS_INSUFFICIENT) |->
        (sub_reg.rest == '0))
        else $error("insufficient payment carries change");

endmodule
`default_nettype wire
